>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error(msg);

`endif

>>> hw/rtl/mosb_pkg.sv
// ----------------------------------------------------------------------------
// mosb_pkg
// Types, constants and helpers of the Morton stream octree builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mosb_pkg;

   localparam int MAX_DEPTH = 6;
   localparam int FANOUT    = 8;
   localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
   localparam int POS_W     = 3 * MAX_DEPTH + 1;
   localparam int ADDR_W    = 19;
   localparam int MORTON_W  = 18;
   localparam int PAYLOAD_W = 32;
   localparam int MASK_W    = 8;
   localparam int FILL_W    = 4;
   localparam int KIND_W    = 2;
   localparam int DEPTH_W   = 3;
   localparam int ENTRIES   = (MAX_DEPTH + 1) * FANOUT;
   localparam int MEM_AW    = $clog2(ENTRIES);
   localparam int DEPTH_RESET = 6;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NODE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [MASK_W-1:0] mask;
      logic [ADDR_W-1:0] data;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ADDR_W-1:0]    address;
      logic [ADDR_W-1:0]    child_base;
      logic [MASK_W-1:0]    child_mask;
      logic [ADDR_W-1:0]    data_address;
      logic [PAYLOAD_W-1:0] record_payload;
      logic                 last;
   } rec_type;

   typedef struct packed {
      logic emit;
      logic flush;
   } out_ctl_type;

   typedef struct packed {
      logic room;
      logic pend_valid;
   } out_sts_type;

   typedef struct packed {
      logic [LVL_W-1:0] lvl;
      logic [POS_W-1:0] span;
   } pad_type;

   // largest aligned block of empty positions that fits below the target
   function automatic pad_type pad_step(input logic [POS_W-1:0] cur,
                                        input logic [POS_W-1:0] tgt,
                                        input logic [LVL_W-1:0] dep);
      pad_type          r;
      logic             ok;
      logic [POS_W:0]   sum;
      logic [POS_W-1:0] sp;
      r.lvl  = dep;
      r.span = POS_W'(1);
      ok     = 1'b1;
      for (int i = 1; i <= MAX_DEPTH; i++) begin
         sp  = POS_W'(1) << (3 * i);
         sum = {1'b0, cur} + {1'b0, sp};
         if (ok && (LVL_W'(i) <= dep) && ((cur & (sp - POS_W'(1))) == '0) &&
             (sum <= {1'b0, tgt})) begin
            r.lvl  = dep - LVL_W'(i);
            r.span = sp;
         end else begin
            ok = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/mosb_if.sv
// ----------------------------------------------------------------------------
// mosb_if
// Voxel request and record response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mosb_req_if import mosb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [MORTON_W-1:0]  morton;
   logic                 has_data;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, op, morton, has_data, payload, input ready);
   modport sink   (input valid, op, morton, has_data, payload, output ready);
endinterface

interface mosb_rsp_if import mosb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [ADDR_W-1:0]    address;
   logic [ADDR_W-1:0]    child_base;
   logic [MASK_W-1:0]    child_mask;
   logic [ADDR_W-1:0]    data_address;
   logic [PAYLOAD_W-1:0] record_payload;
   logic                 last;

   modport source (output valid, kind, address, child_base, child_mask,
                   data_address, record_payload, last, input ready);
   modport sink   (input valid, kind, address, child_base, child_mask,
                   data_address, record_payload, last, output ready);
endinterface

>>> hw/rtl/mosb_ram.sv
// ----------------------------------------------------------------------------
// mosb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mosb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/mosb_out.sv
// ----------------------------------------------------------------------------
// mosb_out
// Record output stage: one held word to mark the last, one output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mosb_out import mosb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  out_ctl_type ctl,
   input  rec_type     rec_in,
   output out_sts_type sts,
   mosb_rsp_if.source  rsp
);

   logic    out_valid_ff, out_valid_in;
   logic    pend_valid_ff, pend_valid_in;
   rec_type out_ff, out_in;
   rec_type pend_ff, pend_in;
   logic    out_free;

   assign out_free       = !out_valid_ff || rsp.ready;
   assign sts.room       = !pend_valid_ff || out_free;
   assign sts.pend_valid = pend_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (ctl.emit && sts.room) begin
         // hold the new word; the previous one is known not to be last
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
         end
         pend_valid_in = 1'b1;
         pend_in       = rec_in;
      end else if (ctl.flush && pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_ff.kind;
   assign rsp.address        = out_ff.address;
   assign rsp.child_base     = out_ff.child_base;
   assign rsp.child_mask     = out_ff.child_mask;
   assign rsp.data_address   = out_ff.data_address;
   assign rsp.record_payload = out_ff.record_payload;
   assign rsp.last           = out_ff.last;

endmodule

>>> hw/rtl/morton_stream_octree_builder.sv
// ----------------------------------------------------------------------------
// morton_stream_octree_builder
// Bottom-up sparse voxel octree builder over a Morton-ordered voxel stream.
// ----------------------------------------------------------------------------
// Usage: voxel words enter on req_ch (op add or finish); records leave on
// rsp_ch, with last set on the final record of each request. csr_wr_en with
// csr_wr_data sets the depth and restarts the tree; write it while idle.
// Per-level node buffers sit in one 56-entry RAM with registered reads;
// fill counts and addresses are in flip-flops.
// Requests are taken one at a time: after acceptance a request runs its
// padding pushes and, for each level buffer that fills, a collapse (8
// slots, each read then checked, then a push of the parent) before
// ready returns; an error word goes straight to the flush. A lack of room
// in the output stage stalls this. The collapse scan through the single
// RAM read port sets the rate.
// Words are held one back in the output stage so last can be marked; a word
// reaches rsp_ch when the next one is formed or at the closing flush.
// Reset: synchronous; depth returns to 6, the tree is empty, the next data
// address is 1. The RAM is not cleared; every entry is written before read.
// Receiver stall: the output register holds and the builder waits;
// req_ch.ready stays low until the last word of the request is in the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module morton_stream_octree_builder import mosb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   mosb_req_if.sink           req_ch,
   mosb_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [DEPTH_W-1:0] csr_wr_data
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_PAD     = 8'b0000_0010,
      ST_PUSH    = 8'b0000_0100,
      ST_COL_RD  = 8'b0000_1000,
      ST_COL_EV  = 8'b0001_0000,
      ST_ROOT_RD = 8'b0010_0000,
      ST_ROOT_EV = 8'b0100_0000,
      ST_FLUSH   = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [POS_W-1:0]     cur_ff, cur_in;
   logic [ADDR_W-1:0]    node_addr_ff, node_addr_in;
   logic [ADDR_W-1:0]    data_addr_ff, data_addr_in;
   logic [FILL_W-1:0]    fill_ff [MAX_DEPTH+1];
   logic [FILL_W-1:0]    fill_in [MAX_DEPTH+1];
   logic                 leaf_done_ff, leaf_done_in;
   logic                 op_ff, op_in;
   logic [MORTON_W-1:0]  morton_ff, morton_in;
   logic                 has_data_ff, has_data_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [2:0]           k_ff, k_in;
   node_type             node_ff, node_in;
   node_type             parent_ff, parent_in;

   logic [LVL_W-1:0]     eff;
   logic [POS_W-1:0]     total;
   logic [POS_W-1:0]     target;
   logic [POS_W-1:0]     req_pos;
   pad_type              ps;
   logic                 mem_we, mem_re;
   logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
   logic [NODE_W-1:0]    mem_rdata;
   node_type             rd;
   logic                 rd_null;
   out_ctl_type          ctl;
   out_sts_type          sts;
   rec_type              rec;

   always_comb begin
      if (depth_ff == '0) begin
         eff = LVL_W'(1);
      end else if (32'(depth_ff) > MAX_DEPTH) begin
         eff = LVL_W'(MAX_DEPTH);
      end else begin
         eff = LVL_W'(depth_ff);
      end
   end

   assign total     = POS_W'(1) << (eff * 3);
   assign target    = (op_ff == OP_FINISH) ? total : POS_W'(morton_ff);
   assign req_pos   = POS_W'(req_ch.morton);
   assign ps        = pad_step(cur_ff, target, eff);
   assign rd        = node_type'(mem_rdata);
   assign rd_null   = (rd.mask == '0) && (rd.data == '0);
   assign mem_waddr = {lvl_ff, fill_ff[lvl_ff][2:0]};

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      node_type          par;
      logic [FILL_W-1:0] fill_n;
      state_in     = state_ff;
      depth_in     = depth_ff;
      cur_in       = cur_ff;
      node_addr_in = node_addr_ff;
      data_addr_in = data_addr_ff;
      fill_in      = fill_ff;
      leaf_done_in = leaf_done_ff;
      op_in        = op_ff;
      morton_in    = morton_ff;
      has_data_in  = has_data_ff;
      payload_in   = payload_ff;
      lvl_in       = lvl_ff;
      k_in         = k_ff;
      node_in      = node_ff;
      parent_in    = parent_ff;
      ctl          = '0;
      rec          = '0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      par          = parent_ff;
      fill_n       = fill_ff[lvl_ff] + FILL_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in        = req_ch.op;
               morton_in    = req_ch.morton;
               has_data_in  = req_ch.has_data;
               payload_in   = req_ch.payload;
               leaf_done_in = 1'b0;
               if (req_ch.op == OP_ADD && (req_pos < cur_ff || req_pos >= total)) begin
                  ctl.emit = 1'b1;
                  rec.kind = KIND_ERROR;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (cur_ff < target) begin
               node_in  = '0;
               lvl_in   = ps.lvl;
               cur_in   = cur_ff + ps.span;
               state_in = ST_PUSH;
            end else if (op_ff == OP_FINISH) begin
               state_in = ST_ROOT_RD;
            end else if (leaf_done_ff) begin
               state_in = ST_FLUSH;
            end else if (!has_data_ff) begin
               node_in      = '0;
               lvl_in       = eff;
               cur_in       = cur_ff + POS_W'(1);
               leaf_done_in = 1'b1;
               state_in     = ST_PUSH;
            end else if (sts.room) begin
               ctl.emit           = 1'b1;
               rec.kind           = KIND_DATA;
               rec.address        = data_addr_ff;
               rec.record_payload = payload_ff;
               node_in            = '0;
               node_in.data       = data_addr_ff;
               data_addr_in       = data_addr_ff + ADDR_W'(1);
               lvl_in             = eff;
               cur_in             = cur_ff + POS_W'(1);
               leaf_done_in       = 1'b1;
               state_in           = ST_PUSH;
            end
         end
         ST_PUSH: begin
            mem_we = 1'b1;
            if (fill_n == FILL_W'(FANOUT) && lvl_ff != '0) begin
               fill_in[lvl_ff] = '0;
               k_in            = '0;
               parent_in       = '0;
               state_in        = ST_COL_RD;
            end else begin
               fill_in[lvl_ff] = fill_n;
               state_in        = ST_PAD;
            end
         end
         ST_COL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {lvl_ff, k_ff};
            state_in  = ST_COL_EV;
         end
         ST_COL_EV: begin
            // hold here while a child waits for room at the output
            if (rd_null || sts.room) begin
               if (!rd_null) begin
                  ctl.emit          = 1'b1;
                  rec.kind          = KIND_NODE;
                  rec.address       = node_addr_ff;
                  rec.child_base    = rd.base;
                  rec.child_mask    = rd.mask;
                  rec.data_address  = rd.data;
                  node_addr_in      = node_addr_ff + ADDR_W'(1);
                  if (parent_ff.mask == '0) begin
                     par.base = node_addr_ff;
                  end
                  par.mask = parent_ff.mask | (MASK_W'(1) << k_ff);
               end
               parent_in = par;
               if (k_ff == 3'd7) begin
                  node_in  = par;
                  lvl_in   = lvl_ff - LVL_W'(1);
                  state_in = ST_PUSH;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = ST_COL_RD;
               end
            end
         end
         ST_ROOT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = ST_ROOT_EV;
         end
         ST_ROOT_EV: begin
            if (sts.room) begin
               ctl.emit          = 1'b1;
               rec.kind          = KIND_NODE;
               rec.address       = node_addr_ff;
               rec.child_base    = rd.base;
               rec.child_mask    = rd.mask;
               rec.data_address  = rd.data;
               for (int i = 0; i <= MAX_DEPTH; i++) begin
                  fill_in[i] = '0;
               end
               cur_in       = '0;
               node_addr_in = '0;
               data_addr_in = ADDR_W'(1);
               state_in     = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            ctl.flush = 1'b1;
            if (sts.room) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // depth write restarts the tree
      if (csr_wr_en) begin
         depth_in = csr_wr_data;
         for (int i = 0; i <= MAX_DEPTH; i++) begin
            fill_in[i] = '0;
         end
         cur_in       = '0;
         node_addr_in = '0;
         data_addr_in = ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= DEPTH_W'(DEPTH_RESET);
         cur_ff       <= '0;
         node_addr_ff <= '0;
         data_addr_ff <= ADDR_W'(1);
         leaf_done_ff <= 1'b0;
         for (int i = 0; i <= MAX_DEPTH; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         cur_ff       <= cur_in;
         node_addr_ff <= node_addr_in;
         data_addr_ff <= data_addr_in;
         leaf_done_ff <= leaf_done_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      morton_ff   <= morton_in;
      has_data_ff <= has_data_in;
      payload_ff  <= payload_in;
      lvl_ff      <= lvl_in;
      k_ff        <= k_in;
      node_ff     <= node_in;
      parent_ff   <= parent_in;
   end

   mosb_ram #(
      .WIDTH (NODE_W),
      .DEPTH (ENTRIES)
   ) u_level_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (node_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mosb_out u_out (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .rec_in (rec),
      .sts    (sts),
      .rsp    (rsp_ch)
   );

   `ASSERT_IMPL(a_idle_no_pend, clock, reset, req_ch.ready, !sts.pend_valid, "word held")
   `ASSERT_IMPL(a_push_fill, clock, reset, state_ff == ST_PUSH, fill_ff[lvl_ff] < FILL_W'(FANOUT), "overfull")
   `ASSERT_NEXT(a_csr_clear, clock, reset, csr_wr_en, cur_ff == '0 && data_addr_ff == ADDR_W'(1), "no restart")

endmodule
